// ===== rtl/plt_pkg.sv =====
// Shared types, request and status codes for the positional list table.
// Used by plt_ctrl, plt_dp, positional_list_table_unit, plt_checker and tb_top.
package plt_pkg;

  typedef logic [1:0] req_t;
  localparam req_t REQ_GET = 2'd0;
  localparam req_t REQ_LOC = 2'd1;
  localparam req_t REQ_INS = 2'd2;
  localparam req_t REQ_DEL = 2'd3;

  typedef logic [1:0] st_t;
  localparam st_t ST_OK   = 2'd0;
  localparam st_t ST_POS  = 2'd1;
  localparam st_t ST_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic chk;
    logic init;
    logic rd;
    logic step;
    logic wr_shift;
    logic wr_term;
    logic cmp;
    logic cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic err;
    logic more;
  } sts_t;

  function automatic logic coef_is_nan(input logic [31:0] w);
    return (w[30:23] == 8'hFF) && (w[22:0] != 23'd0);
  endfunction

  function automatic logic coef_equal(input logic [31:0] a, input logic [31:0] b);
    if (coef_is_nan(a) || coef_is_nan(b)) begin
      return 1'b0;
    end
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

// ===== rtl/plt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/plt_ctrl.sv =====
// Request sequencer for the positional list table.
// Depends on plt_pkg; drives plt_dp through cmd_t and reads sts_t.
module plt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  plt_pkg::sts_t sts,
  output plt_pkg::cmd_t cmd
);
  import plt_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_GRD    = 3'd3;
  localparam logic [2:0] S_GCAP   = 3'd4;
  localparam logic [2:0] S_TERM   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    pend_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.chk  = 1'b1;
        cmd.init = 1'b1;
        if (sts.err) begin
          state_nxt = S_FINISH;
        end else if (sts.req == REQ_GET) begin
          state_nxt = S_GRD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rd       = sts.more;
        cmd.step     = sts.more;
        pend_nxt     = sts.more;
        cmd.wr_shift = pend_r && ((sts.req == REQ_INS) || (sts.req == REQ_DEL));
        cmd.cmp      = pend_r && (sts.req == REQ_LOC);
        if (!sts.more && !pend_r) begin
          state_nxt = (sts.req == REQ_INS) ? S_TERM : S_FINISH;
        end
      end
      S_GRD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_GCAP;
      end
      S_GCAP: begin
        cmd.cap   = 1'b1;
        state_nxt = S_FINISH;
      end
      S_TERM: begin
        cmd.wr_term = 1'b1;
        state_nxt   = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/plt_dp.sv =====
// Datapath for the positional list table: request latch, scan counter,
// term RAM, compare and result registers. Depends on plt_pkg and plt_ram.
module plt_dp #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  plt_pkg::cmd_t      cmd,
  output plt_pkg::sts_t      sts,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_position,
  input  logic [31:0]        in_term_coef,
  input  logic signed [31:0] in_term_expn,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [31:0]        out_read_coef,
  output logic signed [31:0] out_read_expn,
  output logic [7:0]         out_entry_count
);
  import plt_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = (CW > 8) ? CW : 8;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  req_t         req_r;
  logic [7:0]   pos_r;
  logic [31:0]  coef_r;
  logic [31:0]  expn_r;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] j_r;
  logic [CW-1:0] jprv_r;
  st_t          st_r;
  logic         found_r;
  logic [31:0]  rc_r;
  logic [31:0]  re_r;
  logic [1:0]   o_status_r;
  logic         o_found_r;
  logic [31:0]  o_coef_r;
  logic [31:0]  o_expn_r;
  logic [7:0]   o_count_r;

  logic [PW:0]   posx, fillx, jx;
  logic          bad_pos;
  logic          full;
  st_t           st_chk;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;
  logic          hit;
  logic [CW+7:0] cnt_ext;

  assign posx  = (PW + 1)'(pos_r);
  assign fillx = (PW + 1)'(fill_r);
  assign jx    = (PW + 1)'(j_r);
  assign full  = (fill_r == MAX_CNT);

  always_comb begin
    if (req_r == REQ_INS) begin
      bad_pos = (posx == '0) || (posx > fillx + 1'b1);
    end else begin
      bad_pos = (posx == '0) || (posx > fillx);
    end
    if (req_r == REQ_LOC) begin
      st_chk = ST_OK;
    end else if (bad_pos) begin
      st_chk = ST_POS;
    end else if ((req_r == REQ_INS) && full) begin
      st_chk = ST_FULL;
    end else begin
      st_chk = ST_OK;
    end
  end

  always_comb begin
    sts.req = req_r;
    sts.err = (st_chk != ST_OK);
    if (req_r == REQ_INS) begin
      sts.more = (jx >= posx);
    end else begin
      sts.more = (j_r < fill_r);
    end
  end

  always_comb begin
    if ((req_r == REQ_INS) || (req_r == REQ_GET)) begin
      ram_raddr = AW'(j_r - 1'b1);
    end else begin
      ram_raddr = AW'(j_r);
    end
    ram_we = cmd.wr_shift || cmd.wr_term;
    if (cmd.wr_term) begin
      ram_waddr = AW'(pos_r - 8'd1);
      ram_wdata = {coef_r, expn_r};
    end else begin
      ram_waddr = (req_r == REQ_INS) ? AW'(jprv_r) : AW'(jprv_r - 1'b1);
      ram_wdata = ram_rdata;
    end
  end

  plt_ram #(
    .WIDTH(64),
    .DEPTH(MAX_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign hit = (ram_rdata[31:0] == expn_r) && coef_equal(ram_rdata[63:32], coef_r);

  always_comb begin
    fill_nxt = fill_r;
    if (st_r == ST_OK) begin
      if (req_r == REQ_INS) begin
        fill_nxt = fill_r + 1'b1;
      end else if (req_r == REQ_DEL) begin
        fill_nxt = fill_r - 1'b1;
      end
    end
  end

  assign cnt_ext = (CW + 8)'(fill_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.out_load) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      pos_r   <= in_position;
      coef_r  <= in_term_coef;
      expn_r  <= in_term_expn;
      found_r <= 1'b0;
      rc_r    <= '0;
      re_r    <= '0;
    end
    if (cmd.chk) begin
      st_r <= st_chk;
    end
    if (cmd.init) begin
      if (req_r == REQ_INS) begin
        j_r <= fill_r;
      end else if (req_r == REQ_LOC) begin
        j_r <= '0;
      end else begin
        j_r <= CW'(pos_r);
      end
    end else if (cmd.step) begin
      j_r <= (req_r == REQ_INS) ? j_r - 1'b1 : j_r + 1'b1;
    end
    if (cmd.rd) begin
      jprv_r <= j_r;
    end
    if (cmd.cmp && hit) begin
      found_r <= 1'b1;
    end
    if (cmd.cap) begin
      rc_r <= ram_rdata[63:32];
      re_r <= ram_rdata[31:0];
    end
    if (cmd.out_load) begin
      o_status_r <= st_r;
      o_found_r  <= found_r;
      o_coef_r   <= rc_r;
      o_expn_r   <= re_r;
      o_count_r  <= cnt_ext[7:0];
    end
  end

  assign out_status      = o_status_r;
  assign out_found       = o_found_r;
  assign out_read_coef   = o_coef_r;
  assign out_read_expn   = o_expn_r;
  assign out_entry_count = o_count_r;

endmodule

// ===== rtl/positional_list_table_unit.sv =====
// Positional list table: get, locate, insert and delete on an ordered term list.
// Get reads one entry; locate scans the stored entries, and insert and delete shift up
// to MAX_ENTRIES of them. A bad position or a full table ends the request without a
// scan. A finished reply waits for out_ready, and a new request is taken only after
// the reply has been loaded into the output registers.
// Reset empties the list (entry count zero); the term RAM itself is not cleared.
module positional_list_table_unit #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_req_type,
  input  logic [7:0]         in_position,
  input  logic [31:0]        in_term_coef,
  input  logic signed [31:0] in_term_expn,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [31:0]        out_read_coef,
  output logic signed [31:0] out_read_expn,
  output logic [7:0]         out_entry_count
);
  import plt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  plt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plt_dp #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_req_type    (in_req_type),
    .in_position    (in_position),
    .in_term_coef   (in_term_coef),
    .in_term_expn   (in_term_expn),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_read_coef  (out_read_coef),
    .out_read_expn  (out_read_expn),
    .out_entry_count(out_entry_count)
  );

endmodule

// ===== bench/plt_checker.sv =====
// Checker for positional_list_table_unit: watches both channels, predicts each reply
// from its own copy of the term list and compares it field by field.
// Depends on plt_pkg for the request and status codes.
module plt_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  plt_pkg::req_t      in_req_type,
  input  logic [7:0]         in_position,
  input  logic [31:0]        in_term_coef,
  input  logic signed [31:0] in_term_expn,
  input  logic               out_valid,
  input  logic               out_ready,
  input  plt_pkg::st_t       out_status,
  input  logic               out_found,
  input  logic [31:0]        out_read_coef,
  input  logic signed [31:0] out_read_expn,
  input  logic [7:0]         out_entry_count,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import plt_pkg::*;

  typedef struct {
    st_t                status;
    logic               found;
    logic [31:0]        coef;
    logic signed [31:0] expn;
    logic [7:0]         count;
  } term_reply_t;

  logic [31:0]        coef_mem [MAX_ENTRIES];
  logic signed [31:0] expn_mem [MAX_ENTRIES];
  int unsigned        stored_terms;
  term_reply_t        awaited_replies [$];

  function automatic bit coef_matches(logic [31:0] a, logic [31:0] b);
    bit a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    bit b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    bit both_zero = ~|{a[30:0], b[30:0]};
    return !a_nan && !b_nan && (both_zero || a == b);
  endfunction

  function automatic term_reply_t serve_request(req_t req, logic [7:0] pos,
                                                logic [31:0] coef,
                                                logic signed [31:0] expn);
    term_reply_t r;
    int n;
    int p;
    n = stored_terms;
    p = pos;
    r = '{status: ST_OK, found: 1'b0, coef: '0, expn: '0, count: '0};
    case (req)
      REQ_GET: begin
        if (p < 1 || p > n) begin
          r.status = ST_POS;
        end else begin
          r.coef = coef_mem[p-1];
          r.expn = expn_mem[p-1];
        end
      end
      REQ_LOC: begin
        for (int j = 0; j < n; j++) begin
          if (expn_mem[j] == expn && coef_matches(coef_mem[j], coef)) begin
            r.found = 1'b1;
            break;
          end
        end
      end
      REQ_INS: begin
        if (p < 1 || p > n + 1) begin
          r.status = ST_POS;
        end else if (n >= MAX_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          for (int j = n; j >= p; j--) begin
            coef_mem[j] = coef_mem[j-1];
            expn_mem[j] = expn_mem[j-1];
          end
          coef_mem[p-1] = coef;
          expn_mem[p-1] = expn;
          n++;
        end
      end
      default: begin
        if (p < 1 || p > n) begin
          r.status = ST_POS;
        end else begin
          for (int j = p; j < n; j++) begin
            coef_mem[j-1] = coef_mem[j];
            expn_mem[j-1] = expn_mem[j];
          end
          n--;
        end
      end
    endcase
    stored_terms = n;
    r.count = 8'(n);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    term_reply_t want;
    if (!rst_n) begin
      stored_terms = 0;
      awaited_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        awaited_replies.push_back(serve_request(in_req_type, in_position,
                                                in_term_coef, in_term_expn));
      end
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          $error("reply with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("found", 32'(want.found), 32'(out_found));
          check_field("read_coef", want.coef, out_read_coef);
          check_field("read_expn", want.expn, out_read_expn);
          check_field("entry_count", 32'(want.count), 32'(out_entry_count));
        end
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the positional_list_table_unit bench: clock, reset, request stimulus,
// reply-side flow control, watchdog and verdict. Depends on plt_pkg and plt_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import plt_pkg::*;

  localparam int MAX_ENTRIES   = 128;
  localparam int RANDOM_REQS   = 1250;
  localparam int STALL_LIMIT   = 20000;
  localparam int RX_HOLD       = 400;
  localparam int DRAIN_CYCLES  = 140;
  localparam int HOLD_AT       = 300;
  localparam int PAUSE_AT      = 600;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  req_t               in_req_type;
  logic [7:0]         in_position;
  logic [31:0]        in_term_coef;
  logic signed [31:0] in_term_expn;
  logic               out_valid;
  logic               out_ready;
  st_t                out_status;
  logic               out_found;
  logic [31:0]        out_read_coef;
  logic signed [31:0] out_read_expn;
  logic [7:0]         out_entry_count;

  int fail_count;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_rx;

  int unsigned        list_fill;
  bit                 growing;
  logic [31:0]        pool_coef [16];
  logic signed [31:0] pool_expn [16];
  int unsigned        pool_wr;

  logic [31:0]        special_coef [8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000,
                                           32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
                                           32'hFFFF_FFFF, 32'h3F80_0000};
  logic signed [31:0] special_expn [5] = '{32'sh0, -32'sd1, 32'sd1,
                                           32'sh8000_0000, 32'sh7FFF_FFFF};

  positional_list_table_unit #(.MAX_ENTRIES(MAX_ENTRIES)) i_dut (.*);

  plt_checker #(.MAX_ENTRIES(MAX_ENTRIES)) i_checker (.*);

  always #4 clk = ~clk;

  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic offer_request(req_t req, logic [7:0] pos, logic [31:0] coef,
                               logic signed [31:0] expn);
    int p;
    p = pos;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_position  <= pos;
    in_term_coef <= coef;
    in_term_expn <= expn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req == REQ_INS && p >= 1 && p <= list_fill + 1 && list_fill < MAX_ENTRIES) begin
      list_fill++;
      pool_coef[pool_wr] = coef;
      pool_expn[pool_wr] = expn;
      pool_wr = (pool_wr + 1) % 16;
    end else if (req == REQ_DEL && p >= 1 && p <= list_fill) begin
      list_fill--;
    end
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pos(int unsigned limit);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10 || limit == 0) return 8'($urandom_range(255));
    if (r < 22) return 8'(limit);
    if (r < 30) return 8'd1;
    return 8'($urandom_range(limit, 1));
  endfunction

  function automatic logic [31:0] pick_coef();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return special_coef[$urandom_range(7)];
    if (r < 55) return pool_coef[$urandom_range(15)];
    return $urandom();
  endfunction

  function automatic logic signed [31:0] pick_expn();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return special_expn[$urandom_range(4)];
    if (r < 55) return pool_expn[$urandom_range(15)];
    return $urandom();
  endfunction

  task automatic random_request();
    int unsigned w;
    int unsigned k;
    logic [31:0] coef;
    w = $urandom_range(99);
    if (growing && list_fill == MAX_ENTRIES && $urandom_range(7) == 0) growing = 1'b0;
    if (!growing && list_fill == 0) growing = 1'b1;
    if (w < (growing ? 60 : 10)) begin
      offer_request(REQ_INS, pick_pos(list_fill + 1), pick_coef(), pick_expn());
    end else if (w < 70) begin
      offer_request(REQ_DEL, pick_pos(list_fill), pick_coef(), pick_expn());
    end else if (w < 85) begin
      offer_request(REQ_GET, pick_pos(list_fill), pick_coef(), pick_expn());
    end else if ($urandom_range(1) == 0) begin
      k = $urandom_range(15);
      coef = pool_coef[k];
      // flip the sign of a zero coefficient so +0 and -0 meet
      if (coef[30:0] == '0 && $urandom_range(1) == 0) coef[31] = ~coef[31];
      offer_request(REQ_LOC, 8'($urandom_range(255)), coef, pool_expn[k]);
    end else begin
      offer_request(REQ_LOC, 8'($urandom_range(255)), pick_coef(), pick_expn());
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_req_type   = REQ_GET;
    in_position   = '0;
    in_term_coef  = '0;
    in_term_expn  = '0;
    hold_rx       = 1'b0;
    send_idle_pct = 21;
    recv_idle_pct = 73;
    list_fill     = 0;
    growing       = 1'b1;
    pool_wr       = 0;
    foreach (pool_coef[k]) begin
      pool_coef[k] = '0;
      pool_expn[k] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_request(REQ_GET, 8'd1, '0, '0);
    offer_request(REQ_DEL, 8'd1, '0, '0);
    offer_request(REQ_INS, 8'd0, 32'h3F80_0000, 32'sd5);
    offer_request(REQ_INS, 8'd2, 32'h3F80_0000, 32'sd5);
    offer_request(REQ_LOC, 8'd0, 32'h0000_0000, 32'sd0);
    offer_request(REQ_INS, 8'd1, 32'h8000_0000, 32'sh7FFF_FFFF);
    offer_request(REQ_INS, 8'd1, 32'h7FC0_0000, 32'sh8000_0000);
    offer_request(REQ_INS, 8'd3, 32'hFFFF_FFFF, -32'sd1);
    offer_request(REQ_INS, 8'd2, 32'h7F80_0000, 32'sd0);
    offer_request(REQ_INS, 8'd255, 32'h1234_5678, 32'sd7);
    offer_request(REQ_LOC, 8'd255, 32'h0000_0000, 32'sh7FFF_FFFF);
    offer_request(REQ_LOC, 8'd0, 32'h7FC0_0000, 32'sh8000_0000);
    offer_request(REQ_LOC, 8'd1, 32'hFFFF_FFFF, -32'sd1);
    offer_request(REQ_LOC, 8'd2, 32'h7F80_0000, 32'sd0);
    offer_request(REQ_LOC, 8'd2, 32'h7F80_0000, 32'sd1);
    for (int p = 0; p <= 5; p++) begin
      offer_request(REQ_GET, 8'(p), '1, '1);
    end
    offer_request(REQ_DEL, 8'd2, '0, '0);
    offer_request(REQ_DEL, 8'd3, '0, '0);
    offer_request(REQ_DEL, 8'd129, '0, '0);
    offer_request(REQ_DEL, 8'd1, '0, '0);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == RANDOM_REQS / 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 21;
      end else if (i == 2 * RANDOM_REQS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == HOLD_AT) hold_rx <= 1'b1;
      if (i == PAUSE_AT) drain_replies();
      random_request();
    end

    drain_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/plt_pkg.sv
rtl/plt_ram.sv
rtl/plt_ctrl.sv
rtl/plt_dp.sv
rtl/positional_list_table_unit.sv
bench/plt_checker.sv
bench/tb_top.sv
